FILE: design/pfde_pkg.sv
// Shared types, command codes and defaults for the page framebuffer draw engine.
`timescale 1ns / 1ps

package pfde_pkg;

    // Default store geometry.
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Fixed field widths.
    localparam int BYTE_W = 8;
    localparam int COL_IN_W = 7;
    localparam int PG_W = 4;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    // Input command kinds.
    localparam logic [2:0] KIND_POINT = 3'd0;
    localparam logic [2:0] KIND_FIELD = 3'd1;
    localparam logic [2:0] KIND_LINE  = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Operations carried out by the back end.
    typedef enum logic [1:0] {
        OP_RMW,
        OP_LINE,
        OP_CLEAR,
        OP_READ
    } t_op;

    // One classified command. For OP_CLEAR, pg0 and pg1 are the first and last page.
    typedef struct packed {
        t_op                 op;
        logic [PG_W-1:0]     pg0;
        logic [PG_W-1:0]     pg1;
        logic [COL_IN_W-1:0] col;
        logic                en0;
        logic                en1;
        logic [BYTE_W-1:0]   mask0;
        logic [BYTE_W-1:0]   bits0;
        logic [BYTE_W-1:0]   mask1;
        logic [BYTE_W-1:0]   bits1;
    } t_cmd;

endpackage

FILE: design/pfde_front.sv
// Front end: accepts commands, turns them into masked byte operations and queues them.
`timescale 1ns / 1ps

module pfde_front #(
    parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfde_pkg::PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_init,
    input  logic                          i_inverse,
    input  logic [2:0]                    i_kind,
    input  logic [pfde_pkg::COL_IN_W-1:0] i_column,
    input  logic [5:0]                    i_row,
    input  logic                          i_fill,
    input  logic [7:0]                    i_field_value,
    input  logic [3:0]                    i_field_bits,
    input  logic [2:0]                    i_first_page,
    input  logic [2:0]                    i_last_page,
    output logic                          o_cmd_valid,
    output pfde_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);

    logic [pfde_pkg::PG_W-1:0]   page;
    logic [pfde_pkg::PG_W-1:0]   page1;
    logic [pfde_pkg::PG_W-1:0]   last_clip;
    logic [2:0]                  rem;
    logic                        col_ok;
    logic                        ok0;
    logic                        ok1;
    logic [3:0]                  fb;
    logic [8:0]                  m9;
    logic [7:0]                  m;
    logic [15:0]                 wide;
    logic [15:0]                 data;
    logic [7:0]                  pos;
    logic                        need;
    pfde_pkg::t_cmd              cmd;

    pfde_pkg::t_cmd              r_q [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic                        enq;
    logic                        deq;

    // Address checks and field masks.
    always_comb begin
        page      = {1'b0, i_row[5:3]};
        page1     = page + 4'd1;
        rem       = i_row[2:0];
        col_ok    = int'(i_column) < COLUMNS;
        ok0       = col_ok && (int'(page) < PAGES);
        ok1       = col_ok && (int'(page1) < PAGES);
        fb        = (i_field_bits > 4'd8) ? 4'd8 : i_field_bits;
        m9        = (9'd1 << fb) - 9'd1;
        m         = m9[7:0];
        wide      = {8'd0, m} << rem;
        data      = {8'd0, i_field_value & m} << rem;
        pos       = 8'd1 << rem;
        last_clip = (int'(i_last_page) >= PAGES) ? pfde_pkg::PG_W'(PAGES - 1)
                                                 : {1'b0, i_last_page};
    end

    // Classify the command; commands with no effect are not queued.
    always_comb begin
        cmd       = '0;
        cmd.op    = pfde_pkg::OP_RMW;
        cmd.col   = i_column;
        cmd.pg0   = page;
        cmd.pg1   = page1;
        need      = 1'b0;
        case (i_kind)
            pfde_pkg::KIND_POINT: begin
                cmd.en0   = ok0;
                cmd.mask0 = pos;
                cmd.bits0 = (i_fill ^ i_inverse) ? pos : 8'd0;
                need      = ok0;
            end
            pfde_pkg::KIND_FIELD: begin
                cmd.en0   = ok0 && (fb != 4'd0);
                cmd.en1   = ok1 && (fb != 4'd0) && (wide[15:8] != 8'd0);
                cmd.mask0 = wide[7:0];
                cmd.bits0 = data[7:0];
                cmd.mask1 = wide[15:8];
                cmd.bits1 = data[15:8];
                need      = cmd.en0 || cmd.en1;
            end
            pfde_pkg::KIND_LINE: begin
                cmd.op    = pfde_pkg::OP_LINE;
                cmd.mask0 = pos;
                need      = int'(page) < PAGES;
            end
            pfde_pkg::KIND_CLEAR: begin
                cmd.op  = pfde_pkg::OP_CLEAR;
                cmd.pg0 = {1'b0, i_first_page};
                cmd.pg1 = last_clip;
                need    = last_clip >= {1'b0, i_first_page};
            end
            pfde_pkg::KIND_READ: begin
                cmd.op  = pfde_pkg::OP_READ;
                cmd.en0 = ok0;
                need    = 1'b1;
            end
            default: begin
                need = 1'b0;
            end
        endcase
    end

    // Two-entry command queue toward the back end.
    assign o_full      = (r_cnt == 2'd2) || i_init;
    assign enq         = i_push && !o_full && need;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign deq         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (deq) begin
                r_rp <= ~r_rp;
            end
            case ({enq, deq})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: design/pfde_back.sv
// Back end: pixel store, command sequencer and result register.
`timescale 1ns / 1ps

module pfde_back #(
    parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfde_pkg::PAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  pfde_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_init,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_page_byte
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD0,
        S_WR0,
        S_RD1,
        S_WR1,
        S_LRD,
        S_LWR,
        S_RQ,
        S_RES
    } t_state;

    t_state                    r_state;
    pfde_pkg::t_cmd            r_cmd;
    logic [pfde_pkg::PG_W-1:0] r_pg;
    logic [pfde_pkg::PG_W-1:0] r_last;
    logic [COL_W-1:0]          r_col;
    logic                      r_init;
    logic                      r_out_valid;
    logic [7:0]                r_out_data;
    logic [7:0]                r_rdata;
    logic [7:0]                r_mem [DEPTH];

    logic                      mem_we;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [7:0]                mem_wdata;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [pfde_pkg::PG_W-1:0] pg,
                                                 input logic [7:0] col);
        return ADDR_W'(int'(pg) * COLUMNS + int'(col));
    endfunction

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_init      = r_init;
    assign o_empty     = !r_out_valid;
    assign o_page_byte = r_out_data;

    // Memory port control for each sequencer step.
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = f_addr(r_cmd.pg0, {1'b0, r_cmd.col});
        mem_raddr = f_addr(r_cmd.pg0, {1'b0, r_cmd.col});
        mem_wdata = 8'd0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_pg, 8'(r_col));
            end
            S_RD0: begin
                mem_re = 1'b1;
            end
            S_WR0: begin
                mem_we    = 1'b1;
                mem_wdata = (r_rdata & ~r_cmd.mask0) | (r_cmd.bits0 & r_cmd.mask0);
            end
            S_RD1: begin
                mem_re    = 1'b1;
                mem_raddr = f_addr(r_cmd.pg1, {1'b0, r_cmd.col});
            end
            S_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_cmd.pg1, {1'b0, r_cmd.col});
                mem_wdata = (r_rdata & ~r_cmd.mask1) | (r_cmd.bits1 & r_cmd.mask1);
            end
            S_LRD: begin
                mem_re    = 1'b1;
                mem_raddr = f_addr(r_cmd.pg0, 8'(r_col));
            end
            S_LWR: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_cmd.pg0, 8'(r_col));
                mem_wdata = r_rdata | r_cmd.mask0;
            end
            S_RQ: begin
                mem_re = r_cmd.en0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Pixel store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Sequencer. Reset starts a clearing pass over every page.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_pg        <= '0;
            r_last      <= pfde_pkg::PG_W'(PAGES - 1);
            r_col       <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // A result transfer frees the register unless a new result is loaded now.
            if (i_pop && r_out_valid && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_col <= '0;
                        r_pg  <= i_cmd.pg0;
                        r_last <= i_cmd.pg1;
                        case (i_cmd.op)
                            pfde_pkg::OP_RMW:   r_state <= i_cmd.en0 ? S_RD0 : S_RD1;
                            pfde_pkg::OP_LINE:  r_state <= S_LRD;
                            pfde_pkg::OP_CLEAR: r_state <= S_CLR;
                            pfde_pkg::OP_READ:  r_state <= S_RQ;
                            default:            r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_col == COL_LAST) begin
                        r_col <= '0;
                        if (r_pg == r_last) begin
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pg <= r_pg + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_RD0: r_state <= S_WR0;
                S_WR0: r_state <= r_cmd.en1 ? S_RD1 : S_IDLE;
                S_RD1: r_state <= S_WR1;
                S_WR1: r_state <= S_IDLE;
                S_LRD: r_state <= S_LWR;
                S_LWR: begin
                    if (r_col == COL_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_LRD;
                    end
                end
                S_RQ: r_state <= S_RES;
                S_RES: begin
                    // Wait until the result register is free or being emptied.
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_cmd.en0 ? r_rdata : 8'd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/page_framebuffer_draw_engine.sv
// Top level of the page framebuffer draw engine: configuration port and the two halves.
`timescale 1ns / 1ps

// A PAGES x COLUMNS byte framebuffer (bit n of a byte is row 8*page+n) driven by
// point, bit field, horizontal line, page clear and byte read commands. After
// reset the whole store is cleared in one pass, during which full stays high.
// Commands enter a two-deep queue and are executed by a sequencer: a point or
// single-page field is one read and one write of the store, a field that crosses
// a page two of each, a read one store read plus any wait for the result
// register, a line a read and a write of each column and a page clear a write of
// each column of each cleared page. Commands with no effect are accepted and dropped
// at once. Only a read produces a result, which waits in a one-entry register.
module page_framebuffer_draw_engine #(
    parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfde_pkg::PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_kind,
    input  logic [6:0]  i_column,
    input  logic [5:0]  i_row,
    input  logic        i_fill,
    input  logic [7:0]  i_field_value,
    input  logic [3:0]  i_field_bits,
    input  logic [2:0]  i_first_page,
    input  logic [2:0]  i_last_page,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_page_byte
);

    logic           r_inverse;
    logic           init;
    logic           cmd_valid;
    logic           cmd_pop;
    pfde_pkg::t_cmd cmd;

    // Configuration register: polarity for point drawing.
    assign pready = 1'b1;
    assign prdata = {31'd0, r_inverse};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_inverse <= pwdata[0];
        end
    end

    pfde_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_init        (init),
        .i_inverse     (r_inverse),
        .i_kind        (i_kind),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_fill        (i_fill),
        .i_field_value (i_field_value),
        .i_field_bits  (i_field_bits),
        .i_first_page  (i_first_page),
        .i_last_page   (i_last_page),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    pfde_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_init      (init),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_page_byte (o_page_byte)
    );

endmodule

FILE: design/pfde_checker.sv
// Port-level checks for the page framebuffer draw engine, bound to the top level.
`timescale 1ns / 1ps

module pfde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_page_byte
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // The clearing pass after reset holds off input.
    a_reset_full: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input accepted during clearing pass");

    // A waiting result is not withdrawn.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped before transfer");

    // A waiting result keeps its value.
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_page_byte))
        else $error("result changed before transfer");

    // A register write is visible on read data afterwards.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2])
        |=> (prdata == {31'd0, $past(pwdata[0])}))
        else $error("polarity register write lost");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_page_byte (o_page_byte)
);
